>>> design/qoi_pixel_stream_encoder_core_defines.svh
// assertion macros for the qoi pixel stream encoder core
// used by the top level; expects i_clk and i_rst_n in the including scope
`ifndef QOI_PIXEL_STREAM_ENCODER_CORE_DEFINES_SVH
`define QOI_PIXEL_STREAM_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QOI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("qoi core assertion failed");
`define QOI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qoi core assertion failed");
`else
`define QOI_ASSERT(lbl, prop)
`define QOI_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> design/qoi_pkg.sv
// shared types, op codes and the slot hash of the qoi encoder core
// no dependencies
`default_nettype none

package qoi_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    localparam int MAX_BYTES = 6;
    localparam int OP_BYTES  = 5;
    localparam int SLOT_W    = 6;
    localparam int TABLE_DEPTH = 64;

    // one queued command: the bytes of one pixel, oldest in bytes[0]
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
        logic                      last;
    } t_cmd;

    localparam logic [7:0] OP_RUN       = 8'hc0;
    localparam logic [7:0] OP_DIFF      = 8'h40;
    localparam logic [7:0] OP_LUMA      = 8'h80;
    localparam logic [7:0] OP_RGB       = 8'hfe;
    localparam logic [7:0] OP_RGBA      = 8'hff;
    localparam logic [5:0] RUN_MAX      = 6'd62;
    localparam logic [2:0] CHAN_RGBA    = 3'd4;
    localparam logic [2:0] CHAN_RESET   = 3'd4;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam t_pixel PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: ALPHA_OPAQUE};

    // (r*3 + g*5 + b*7 + a*11) mod 64, only the low six bits matter
    function automatic logic [SLOT_W-1:0] slot_hash(input t_pixel p);
        logic [SLOT_W-1:0] s;
        s = p.r[SLOT_W-1:0] * 6'd3 + p.g[SLOT_W-1:0] * 6'd5
          + p.b[SLOT_W-1:0] * 6'd7 + p.a[SLOT_W-1:0] * 6'd11;
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/qoi_pixel_stream_encoder_core.sv
// top level of the qoi op stream encoder: classifier, command queue, byte sequencer
// depends on qoi_pkg, qoi_front, qoi_fifo, qoi_back and the defines header
//
// One pixel goes in per push and comes out as the QOI op bytes it causes, one byte
// per pop, oldest first; pixel_done marks the last byte of a pixel and image_done
// the last byte of the image. A pixel is accepted every cycle while the command
// queue (FIFO_DEPTH entries) has room; a pixel is registered in the classifier,
// then its command is written into the queue, and from the queue head its first
// byte shows on the result ports, ready to pop. The sustained pace is set by the
// single byte port of the sequencer, one byte per pop: a pixel makes no bytes
// when absorbed by a run, one for index, diff or a run flush, two for luma, four
// for rgb, five for rgba, plus one when a pending run is flushed ahead.
// The 64-entry seen table is a memory with one valid flip-flop per entry, cleared
// at once at reset and after each final pixel, so no clearing pass is needed.
// channel_count may be written only while the block is idle; values other than 4
// select rgb input with alpha held at 255.
`default_nettype none

`include "qoi_pixel_stream_encoder_core_defines.svh"

module qoi_pixel_stream_encoder_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_alpha,
    input  wire logic       i_final_pixel,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_code_byte,
    output logic            o_pixel_done,
    output logic            o_image_done,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);

    logic [2:0]      r_channel_count;
    qoi_pkg::t_pixel pixel;
    qoi_pkg::t_cmd   cmd;
    qoi_pkg::t_cmd   head;
    logic cmd_valid;
    logic fifo_full;
    logic fifo_empty;
    logic head_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= qoi_pkg::CHAN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_channel_count <= i_cfg_data;
        end
    end

    assign pixel = '{r: i_red, g: i_green, b: i_blue, a: i_alpha};

    qoi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (pixel),
        .i_final     (i_final_pixel),
        .i_rgba      (r_channel_count == qoi_pkg::CHAN_RGBA),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_fifo_full (fifo_full)
    );

    qoi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .o_full  (fifo_full),
        .i_pop   (head_pop),
        .o_data  (head),
        .o_empty (fifo_empty)
    );

    qoi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (fifo_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_byte  (o_code_byte),
        .o_pixel_done (o_pixel_done),
        .o_image_done (o_image_done)
    );

    // the end of an image is always the end of a pixel
    `QOI_ASSERT_IMP(a_image_done_ends_pixel, !empty && o_image_done, o_pixel_done)
    // the classifier never hands a command to a full queue
    `QOI_ASSERT_IMP(a_no_push_when_full, cmd_valid, !fifo_full)
    // the sequencer only retires a command that is there
    `QOI_ASSERT_IMP(a_no_pop_when_empty, head_pop, !fifo_empty)
    // a queued command always carries at least one byte and at most six
    `QOI_ASSERT(a_cmd_len_range, fifo_empty || (head.len != 3'd0 && head.len <= 3'd6))

endmodule

`default_nettype wire

>>> design/qoi_front.sv
// front end: accepts pixels, looks up the seen table and classifies the op
// depends on qoi_pkg; produces one t_cmd per pixel that emits bytes
`default_nettype none

module qoi_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qoi_pkg::t_pixel i_pixel,
    input  wire logic          i_final,
    input  wire logic          i_rgba,
    output logic               o_full,
    output logic               o_cmd_valid,
    output qoi_pkg::t_cmd      o_cmd,
    input  wire logic          i_fifo_full
);

    qoi_pkg::t_pixel in_px;
    logic [qoi_pkg::SLOT_W-1:0] in_slot;
    logic accept;
    logic advance;

    logic                       r_valid;
    qoi_pkg::t_pixel            r_px;
    logic                       r_last;
    logic [qoi_pkg::SLOT_W-1:0] r_slot;
    logic                       r_fwd;
    qoi_pkg::t_pixel            r_rd;
    qoi_pkg::t_pixel            r_prev;
    logic [5:0]                 r_run;
    logic [qoi_pkg::TABLE_DEPTH-1:0] r_tvalid;
    qoi_pkg::t_pixel            r_table [qoi_pkg::TABLE_DEPTH];

    logic same;
    logic entry_hit;
    logic emit;
    logic tbl_we;
    logic run_en;
    logic [5:0] run_inc;
    logic [7:0] run_byte;
    logic [qoi_pkg::OP_BYTES-1:0][7:0] op_bytes;
    logic [2:0] op_len;
    logic [7:0] dr, dg, db, dgr, dgb;
    logic [7:0] dr2, dg2, db2, dg32, dgr8, dgb8;
    logic diff_ok, luma_ok;
    logic [5:0] n_run;

    always_comb begin
        in_px   = i_pixel;
        in_px.a = i_rgba ? i_pixel.a : qoi_pkg::ALPHA_OPAQUE;
        in_slot = qoi_pkg::slot_hash(in_px);
    end

    assign accept = i_push && !o_full;
    assign o_full = r_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    // a write landing in the same cycle as the read makes the read stale;
    // the written entry equals the previous pixel, so it can only miss
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= in_px;
            r_last <= i_final;
            r_slot <= in_slot;
            r_fwd  <= tbl_we && !r_last && (r_slot == in_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[r_slot] <= r_px;
        end
        if (accept) begin
            r_rd <= r_table[in_slot];
        end
    end

    always_comb begin
        same      = (r_px == r_prev);
        // an entry not written since the image began counts as all zeros
        entry_hit = !r_fwd && (r_tvalid[r_slot] ? (r_rd == r_px) : (r_px == '0));
        run_inc   = r_run + 6'd1;

        dr   = r_px.r - r_prev.r;
        dg   = r_px.g - r_prev.g;
        db   = r_px.b - r_prev.b;
        dgr  = dr - dg;
        dgb  = db - dg;
        dr2  = dr + 8'd2;
        dg2  = dg + 8'd2;
        db2  = db + 8'd2;
        dg32 = dg + 8'd32;
        dgr8 = dgr + 8'd8;
        dgb8 = dgb + 8'd8;
        diff_ok = (dr2[7:2] == 6'd0) && (dg2[7:2] == 6'd0) && (db2[7:2] == 6'd0);
        luma_ok = (dg32[7:6] == 2'd0) && (dgr8[7:4] == 4'd0) && (dgb8[7:4] == 4'd0);

        op_bytes = '0;
        op_len   = 3'd1;
        if (entry_hit) begin
            op_bytes[0] = {2'b00, r_slot};
        end else if (r_px.a != r_prev.a) begin
            op_bytes = {r_px.a, r_px.b, r_px.g, r_px.r, qoi_pkg::OP_RGBA};
            op_len   = 3'd5;
        end else if (diff_ok) begin
            op_bytes[0] = qoi_pkg::OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        end else if (luma_ok) begin
            op_bytes[0] = qoi_pkg::OP_LUMA | {2'b00, dg32[5:0]};
            op_bytes[1] = {dgr8[3:0], dgb8[3:0]};
            op_len      = 3'd2;
        end else begin
            op_bytes[3:0] = {r_px.b, r_px.g, r_px.r, qoi_pkg::OP_RGB};
            op_len        = 3'd4;
        end

        o_cmd      = '0;
        o_cmd.last = r_last;
        if (same) begin
            emit          = (run_inc >= qoi_pkg::RUN_MAX) || r_last;
            run_en        = 1'b0;
            run_byte      = qoi_pkg::OP_RUN | {2'b00, r_run};
            o_cmd.bytes[0] = run_byte;
            o_cmd.len     = 3'd1;
            n_run         = emit ? 6'd0 : run_inc;
        end else begin
            emit     = 1'b1;
            run_en   = (r_run != 6'd0);
            run_byte = qoi_pkg::OP_RUN | {2'b00, r_run - 6'd1};
            o_cmd.bytes = run_en ? {op_bytes, run_byte} : {8'h00, op_bytes};
            o_cmd.len   = op_len + {2'b00, run_en};
            n_run       = 6'd0;
        end
    end

    assign advance     = r_valid && (!emit || !i_fifo_full);
    assign o_cmd_valid = r_valid && emit && !i_fifo_full;
    assign tbl_we      = advance && !same && !entry_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= qoi_pkg::PIXEL_RESET;
            r_run    <= 6'd0;
            r_tvalid <= '0;
        end else if (advance) begin
            if (r_last) begin
                // end of image: back to a fresh table and history
                r_prev   <= qoi_pkg::PIXEL_RESET;
                r_run    <= 6'd0;
                r_tvalid <= '0;
            end else begin
                r_prev <= r_px;
                r_run  <= n_run;
                if (tbl_we) begin
                    r_tvalid[r_slot] <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/qoi_fifo.sv
// command queue between the classifier and the byte sequencer
// depends on qoi_pkg for the command type
`default_nettype none

module qoi_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qoi_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output qoi_pkg::t_cmd      o_data,
    output logic               o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qoi_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/qoi_back.sv
// back end: walks the bytes of the head command one per pop
// depends on qoi_pkg for the command type
`default_nettype none

module qoi_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire qoi_pkg::t_cmd i_head,
    input  wire logic          i_head_empty,
    output logic               o_head_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_code_byte,
    output logic               o_pixel_done,
    output logic               o_image_done
);

    logic [2:0] r_idx;
    logic last_byte;
    logic take;

    assign last_byte    = (r_idx == i_head.len - 3'd1);
    assign take         = i_pop && !i_head_empty;
    assign o_head_pop   = take && last_byte;
    assign o_empty      = i_head_empty;
    assign o_code_byte  = i_head.bytes[r_idx];
    assign o_pixel_done = last_byte;
    assign o_image_done = last_byte && i_head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (take) begin
            r_idx <= last_byte ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

`default_nettype wire
